@@ rtl/lstc_pkg.sv @@
// shared types, register codes and switch decoding for the travel calibrator
`timescale 1ns / 1ps
`default_nettype none
package lstc_pkg;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  localparam logic [1:0] AXIS_INVALID = 2'd3;

  localparam logic [1:0] SW_NONE = 2'd0;
  localparam logic [1:0] SW_X    = 2'd1;
  localparam logic [1:0] SW_Y    = 2'd2;
  localparam logic [1:0] SW_Z    = 2'd3;

  localparam logic [1:0] CFG_LOCKOUT    = 2'd0;
  localparam logic [1:0] CFG_MAX_SEARCH = 2'd1;
  localparam logic [1:0] CFG_MAX_TRAVEL = 2'd2;

  localparam logic [15:0] LOCKOUT_RESET    = 16'd50;
  localparam logic [31:0] MAX_SEARCH_RESET = 32'd100000;
  localparam logic [31:0] MAX_TRAVEL_RESET = 32'd1000000;

  typedef struct packed {
    logic [15:0] lockout_steps;
    logic [31:0] max_search_steps;
    logic [31:0] max_travel_steps;
  } cfg_t;

  // switch samples are ordered {z, y, x}
  typedef struct packed {
    logic       func;
    logic [1:0] axis_sel;
    logic [2:0] now;
    logic [2:0] late;
  } item_t;

  typedef struct packed {
    logic        step_request;
    logic [1:0]  step_axis;
    logic        direction;
    logic        run_done;
    logic        run_failed;
    logic [31:0] travel_steps;
  } result_t;

  // id of the single pressed switch, none when zero or several are pressed
  function automatic logic [1:0] switch_id(input logic [2:0] zyx);
    logic [1:0] id;
    case (zyx)
      3'b001:  id = SW_X;
      3'b010:  id = SW_Y;
      3'b100:  id = SW_Z;
      default: id = SW_NONE;
    endcase
    return id;
  endfunction

  function automatic logic [1:0] stable_id(input logic [2:0] now, input logic [2:0] late);
    logic [1:0] s1;
    logic [1:0] s2;
    s1 = switch_id(now);
    s2 = switch_id(late);
    return ((s1 != SW_NONE) && (s1 == s2)) ? s1 : SW_NONE;
  endfunction

endpackage
`default_nettype wire

@@ rtl/lstc_cfg_regs.sv @@
// configuration registers of the travel calibrator
`timescale 1ns / 1ps
`default_nettype none
module lstc_cfg_regs (
  input  wire              clk,
  input  wire              rst,
  input  wire              cfg_valid,
  output logic             cfg_ready,
  input  wire        [1:0] cfg_index,
  input  wire       [31:0] cfg_data,
  output lstc_pkg::cfg_t   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lockout_steps    <= lstc_pkg::LOCKOUT_RESET;
      cfg.max_search_steps <= lstc_pkg::MAX_SEARCH_RESET;
      cfg.max_travel_steps <= lstc_pkg::MAX_TRAVEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lstc_pkg::CFG_LOCKOUT:    cfg.lockout_steps    <= cfg_data[15:0];
        lstc_pkg::CFG_MAX_SEARCH: cfg.max_search_steps <= cfg_data;
        lstc_pkg::CFG_MAX_TRAVEL: cfg.max_travel_steps <= cfg_data;
        default: ; // unused index, write dropped
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/lstc_in_stage.sv @@
// input register stage of the travel calibrator
`timescale 1ns / 1ps
`default_nettype none
module lstc_in_stage (
  input  wire              clk,
  input  wire              rst,
  input  wire              item_valid,
  output logic             item_stall,
  input  lstc_pkg::item_t  item_in,
  input  wire              advance,
  output logic             held_valid,
  output lstc_pkg::item_t  held_item
);

  assign item_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      held_item <= item_in;
    end
  end

endmodule
`default_nettype wire

@@ rtl/lstc_engine.sv @@
// run state, switch filter and result register of the travel calibrator
`timescale 1ns / 1ps
`default_nettype none
module lstc_engine #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire              clk,
  input  wire              rst,
  input  lstc_pkg::cfg_t   cfg,
  input  wire              held_valid,
  input  lstc_pkg::item_t  held_item,
  output logic             advance,
  output logic             result_valid,
  input  wire              result_stall,
  output lstc_pkg::result_t result
);

  localparam int CMP_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SEARCH = 2'd1,
    PH_TRAVEL = 2'd2
  } phase_t;

  phase_t                 phase, phase_next;
  logic                   dir_level, dir_level_next;
  logic [1:0]             run_axis, run_axis_next;
  logic [1:0]             start_switch, start_switch_next;
  logic [1:0]             recent_switch, recent_switch_next;
  logic [15:0]            lock_count, lock_count_next;
  logic [COUNT_WIDTH-1:0] step_count, step_count_next;
  lstc_pkg::result_t      result_next;

  logic                   fire;
  logic [1:0]             id_now;
  logic [1:0]             sw;
  logic [15:0]            lock_dec;
  logic [1:0]             recent_filt;
  logic                   accept;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [CMP_W-1:0]       cnt_ext;
  logic                   search_limit;
  logic                   travel_limit;

  assign advance = !result_valid || !result_stall;
  assign fire    = held_valid && advance;

  // lockout filter as seen by a step item
  always_comb begin
    id_now       = lstc_pkg::switch_id(held_item.now);
    sw           = lstc_pkg::stable_id(held_item.now, held_item.late);
    lock_dec     = (lock_count != 16'd0) ? lock_count - 16'd1 : 16'd0;
    recent_filt  = ((lock_dec == 16'd0) && (id_now == lstc_pkg::SW_NONE)) ?
                   lstc_pkg::SW_NONE : recent_switch;
    accept       = (sw != lstc_pkg::SW_NONE) &&
                   !((sw == recent_filt) && (lock_dec != 16'd0));
    cnt_inc      = step_count + COUNT_WIDTH'(1);
    cnt_ext      = CMP_W'(cnt_inc);
    search_limit = cnt_ext >= CMP_W'(cfg.max_search_steps);
    travel_limit = cnt_ext >= CMP_W'(cfg.max_travel_steps);
  end

  always_comb begin
    phase_next         = phase;
    dir_level_next     = dir_level;
    run_axis_next      = run_axis;
    start_switch_next  = start_switch;
    recent_switch_next = recent_switch;
    lock_count_next    = lock_count;
    step_count_next    = step_count;
    result_next        = '0;

    if (held_item.func == lstc_pkg::FUNC_START) begin
      if (held_item.axis_sel == lstc_pkg::AXIS_INVALID) begin
        phase_next             = PH_IDLE;
        result_next.run_done   = 1'b1;
        result_next.run_failed = 1'b1;
      end else begin
        run_axis_next      = held_item.axis_sel;
        recent_switch_next = lstc_pkg::SW_NONE;
        lock_count_next    = 16'd0;
        step_count_next    = '0;
        if (sw == lstc_pkg::SW_NONE) begin
          if (cfg.max_search_steps == 32'd0) begin
            phase_next             = PH_IDLE;
            result_next.run_done   = 1'b1;
            result_next.run_failed = 1'b1;
          end else begin
            phase_next               = PH_SEARCH;
            result_next.step_request = 1'b1;
          end
        end else begin
          start_switch_next  = sw;
          recent_switch_next = sw;
          lock_count_next    = cfg.lockout_steps;
          if (cfg.max_travel_steps == 32'd0) begin
            phase_next             = PH_IDLE;
            result_next.run_done   = 1'b1;
            result_next.run_failed = 1'b1;
          end else begin
            phase_next               = PH_TRAVEL;
            result_next.step_request = 1'b1;
          end
        end
      end
    end else begin
      unique case (phase)
        PH_IDLE: ;
        PH_SEARCH: begin
          step_count_next    = cnt_inc;
          recent_switch_next = accept ? sw : recent_filt;
          lock_count_next    = accept ? cfg.lockout_steps : lock_dec;
          if (accept) begin
            start_switch_next = sw;
            dir_level_next    = !dir_level;
            step_count_next   = '0;
            if (cfg.max_travel_steps == 32'd0) begin
              phase_next             = PH_IDLE;
              result_next.run_done   = 1'b1;
              result_next.run_failed = 1'b1;
            end else begin
              phase_next               = PH_TRAVEL;
              result_next.step_request = 1'b1;
            end
          end else if (search_limit) begin
            phase_next             = PH_IDLE;
            result_next.run_done   = 1'b1;
            result_next.run_failed = 1'b1;
          end else begin
            result_next.step_request = 1'b1;
          end
        end
        PH_TRAVEL: begin
          step_count_next    = cnt_inc;
          recent_switch_next = accept ? sw : recent_filt;
          lock_count_next    = accept ? cfg.lockout_steps : lock_dec;
          // the far switch ends the run, the start switch only relocks
          if (accept && (sw != start_switch)) begin
            dir_level_next           = !dir_level;
            phase_next               = PH_IDLE;
            result_next.run_done     = 1'b1;
            result_next.travel_steps = cnt_ext[31:0];
          end else if (travel_limit) begin
            phase_next             = PH_IDLE;
            result_next.run_done   = 1'b1;
            result_next.run_failed = 1'b1;
          end else begin
            result_next.step_request = 1'b1;
          end
        end
        default: ;
      endcase
    end

    result_next.step_axis = run_axis_next;
    result_next.direction = dir_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      dir_level     <= 1'b1;
      run_axis      <= 2'd0;
      start_switch  <= lstc_pkg::SW_NONE;
      recent_switch <= lstc_pkg::SW_NONE;
      lock_count    <= 16'd0;
      step_count    <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (advance) begin
        result_valid <= held_valid;
      end
      if (fire) begin
        phase         <= phase_next;
        dir_level     <= dir_level_next;
        run_axis      <= run_axis_next;
        start_switch  <= start_switch_next;
        recent_switch <= recent_switch_next;
        lock_count    <= lock_count_next;
        step_count    <= step_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/limit_switch_travel_calibrator_unit.sv @@
// top level of the limit switch travel calibrator
// an item passes the input register and then the result register on its way to the output
// throughput: one item per cycle unless the result stalls; the single state update sets it
// a stalled result holds the result register; the input register still takes one more item
// reset (rst, synchronous): idle, direction level 1, axis x, counters and lockout cleared,
// registers back to lockout 50, search limit 100000, travel limit 1000000
`timescale 1ns / 1ps
`default_nettype none
module limit_switch_travel_calibrator_unit #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data,
  input  wire         item_valid,
  output logic        item_stall,
  input  wire         func,
  input  wire  [1:0]  axis_sel,
  input  wire         x_now,
  input  wire         y_now,
  input  wire         z_now,
  input  wire         x_late,
  input  wire         y_late,
  input  wire         z_late,
  output logic        result_valid,
  input  wire         result_stall,
  output logic        step_request,
  output logic [1:0]  step_axis,
  output logic        direction,
  output logic        run_done,
  output logic        run_failed,
  output logic [31:0] travel_steps
);

  lstc_pkg::cfg_t    cfg;
  lstc_pkg::item_t   item_in;
  lstc_pkg::item_t   held_item;
  lstc_pkg::result_t result;
  logic              held_valid;
  logic              advance;

  assign item_in.func     = func;
  assign item_in.axis_sel = axis_sel;
  assign item_in.now      = {z_now, y_now, x_now};
  assign item_in.late     = {z_late, y_late, x_late};

  lstc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lstc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_in    (item_in),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  lstc_engine #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .held_valid   (held_valid),
    .held_item    (held_item),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign step_request = result.step_request;
  assign step_axis    = result.step_axis;
  assign direction    = result.direction;
  assign run_done     = result.run_done;
  assign run_failed   = result.run_failed;
  assign travel_steps = result.travel_steps;

endmodule
`default_nettype wire

@@ rtl/lstc_checker.sv @@
// port level checks of the travel calibrator and their bind
`timescale 1ns / 1ps
`default_nettype none
module lstc_checker (
  input wire        clk,
  input wire        rst,
  input wire        result_valid,
  input wire        result_stall,
  input wire        step_request,
  input wire [1:0]  step_axis,
  input wire        direction,
  input wire        run_done,
  input wire        run_failed,
  input wire [31:0] travel_steps
);

  // a stalled result holds until its transfer
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid &&
      $stable({step_request, step_axis, direction, run_done, run_failed, travel_steps}))
    else $error("stalled result changed");

  // failure only ends a run, and carries no count
  a_fail_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && run_failed |-> run_done && (travel_steps == 32'd0))
    else $error("failed result without done or with a count");

  // a finished run asks for no further step
  a_done_no_step: assert property (@(posedge clk) disable iff (rst)
    result_valid && run_done |-> !step_request)
    else $error("step requested on a finished run");

  // the driven axis is never the invalid code
  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (step_axis != 2'd3))
    else $error("step axis out of range");

endmodule

bind limit_switch_travel_calibrator_unit lstc_checker u_lstc_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .step_request (step_request),
  .step_axis    (step_axis),
  .direction    (direction),
  .run_done     (run_done),
  .run_failed   (run_failed),
  .travel_steps (travel_steps)
);
`default_nettype wire
